/* rtl/spq_pkg.sv */
// Shared types and constants for the sorted priority queue.
// No dependencies; every other file of the block refers to it by scoped names.
package spq_pkg;

  // Default sizes of the queue.
  localparam int unsigned DEPTH_DEF    = 16;
  localparam int unsigned TAG_BITS_DEF = 16;

  // Fixed widths of the item fields.
  localparam int unsigned TAG_W  = 16;
  localparam int unsigned PRI_W  = 8;
  localparam int unsigned KIND_W = 2;
  localparam int unsigned STAT_W = 2;

  // Kind of an input item.
  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT = 2'd0,
    KIND_POP    = 2'd1,
    KIND_MATCH  = 2'd2,
    KIND_LIST   = 2'd3
  } spq_kind_e;

  // Status of a result item.
  typedef enum logic [STAT_W-1:0] {
    STAT_OK      = 2'd0,
    STAT_FULL    = 2'd1,
    STAT_EMPTY   = 2'd2,
    STAT_NOMATCH = 2'd3
  } spq_status_e;

  // Operation that the row of cells performs.
  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_POP,
    OP_ROTATE
  } spq_op_e;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LIST,
    ST_MATCH,
    ST_MATCH_END
  } spq_state_e;

  // Command broadcast to every cell.
  typedef struct packed {
    spq_op_e          op;
    logic [PRI_W-1:0] pri;
  } spq_ctrl_t;

endpackage

/* rtl/spq_in_if.sv */
// Input channel of the sorted priority queue: valid/ready plus the request fields.
// Depends on spq_pkg for the field widths.
interface spq_in_if;
  logic                          valid;
  logic                          ready;
  logic [spq_pkg::KIND_W-1:0]    kind;
  logic [spq_pkg::TAG_W-1:0]     tag;
  logic [spq_pkg::PRI_W-1:0]     priority_req;

  modport source (output valid, kind, tag, priority_req, input ready);
  modport sink   (input valid, kind, tag, priority_req, output ready);
endinterface

/* rtl/spq_out_if.sv */
// Output channel of the sorted priority queue: valid/ready plus the result fields.
// Depends on spq_pkg for the field widths.
interface spq_out_if;
  logic                          valid;
  logic                          ready;
  logic [spq_pkg::TAG_W-1:0]     out_tag;
  logic [spq_pkg::PRI_W-1:0]     out_priority;
  logic [spq_pkg::STAT_W-1:0]    status;
  logic                          last;

  modport source (output valid, out_tag, out_priority, status, last, input ready);
  modport sink   (input valid, out_tag, out_priority, status, last, output ready);
endinterface

/* rtl/spq_cell.sv */
// One slot of the sorted row: holds a tag and a priority and trades them with
// its neighbors on insert, pop and rotate. Depends on spq_pkg.
module spq_cell #(
  parameter int unsigned DEPTH    = spq_pkg::DEPTH_DEF,
  parameter int unsigned TAG_BITS = spq_pkg::TAG_BITS_DEF,
  parameter int unsigned IDX      = 0,
  localparam int unsigned OW      = $clog2(DEPTH + 1)
) (
  input  logic                       clk_i,
  input  spq_pkg::spq_ctrl_t         ctrl_i,
  input  logic [OW-1:0]              occ_i,
  input  logic [TAG_BITS-1:0]        new_tag_i,
  input  logic [TAG_BITS-1:0]        left_tag_i,
  input  logic [spq_pkg::PRI_W-1:0]  left_pri_i,
  input  logic                       left_keep_i,
  input  logic [TAG_BITS-1:0]        right_tag_i,
  input  logic [spq_pkg::PRI_W-1:0]  right_pri_i,
  input  logic [TAG_BITS-1:0]        head_tag_i,
  input  logic [spq_pkg::PRI_W-1:0]  head_pri_i,
  output logic [TAG_BITS-1:0]        tag_o,
  output logic [spq_pkg::PRI_W-1:0]  pri_o,
  output logic                       keep_o
);

  logic [TAG_BITS-1:0]       tag_q, tag_d;
  logic [spq_pkg::PRI_W-1:0] pri_q, pri_d;
  logic                      occupied;
  logic                      is_tail;

  // The slot holds an entry when it lies below the fill count.
  assign occupied = OW'(IDX) < occ_i;
  assign is_tail  = OW'(IDX) == (occ_i - 1'b1);

  // An occupied slot of equal or higher priority stays ahead of a new entry.
  assign keep_o = occupied && (pri_q >= ctrl_i.pri);

  // Select the next contents of the slot.
  always_comb begin
    tag_d = tag_q;
    pri_d = pri_q;
    case (ctrl_i.op)
      spq_pkg::OP_INSERT: begin
        if (!keep_o) begin
          if (left_keep_i) begin
            tag_d = new_tag_i;
            pri_d = ctrl_i.pri;
          end else begin
            tag_d = left_tag_i;
            pri_d = left_pri_i;
          end
        end
      end
      spq_pkg::OP_POP: begin
        tag_d = right_tag_i;
        pri_d = right_pri_i;
      end
      spq_pkg::OP_ROTATE: begin
        if (is_tail) begin
          tag_d = head_tag_i;
          pri_d = head_pri_i;
        end else begin
          tag_d = right_tag_i;
          pri_d = right_pri_i;
        end
      end
      default: begin
        tag_d = tag_q;
        pri_d = pri_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    tag_q <= tag_d;
    pri_q <= pri_d;
  end

  assign tag_o = tag_q;
  assign pri_o = pri_q;

endmodule

/* rtl/sorted_priority_queue_core.sv */
// Sorted priority queue of DEPTH entries, highest priority at the head and
// first-come order among equal priorities, kept in a row of cells with a fill
// count. On insert and pop the row shifts by one slot in the cycle the item is
// accepted and the single result is loaded into the output register. A listing
// of all entries accepts the item, then gives one result per cycle as the row
// rotates its entries past the head; a match listing rotates the same way, then
// a closing state flushes the final match with its last flag. An empty queue or
// a failed insert loads its result in the cycle that accepts the item. Any
// cycle in which the output register is full and not taken stalls the
// sequencer. No clearing pass is needed after reset. Depends on spq_pkg,
// spq_in_if, spq_out_if and spq_cell.
module sorted_priority_queue_core #(
  parameter int unsigned DEPTH    = spq_pkg::DEPTH_DEF,
  parameter int unsigned TAG_BITS = spq_pkg::TAG_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  spq_in_if.sink    in_i,
  spq_out_if.source out_o
);

  localparam int unsigned OW = $clog2(DEPTH + 1);
  localparam int unsigned CW = $clog2(DEPTH);
  localparam int unsigned TW = spq_pkg::TAG_W;
  localparam int unsigned PW = spq_pkg::PRI_W;

  spq_pkg::spq_state_e state_q, state_d;
  logic [OW-1:0]       occ_q, occ_d;
  logic [CW-1:0]       cnt_q, cnt_d;
  logic                pend_v_q, pend_v_d;
  logic [TW-1:0]       pend_tag_q, pend_tag_d;
  logic [PW-1:0]       pend_pri_q, pend_pri_d;
  logic [PW-1:0]       match_pri_q, match_pri_d;

  logic                out_valid_q;
  logic [TW-1:0]       out_tag_q;
  logic [PW-1:0]       out_pri_q;
  spq_pkg::spq_status_e out_stat_q;
  logic                out_last_q;

  logic                ld;
  logic [TW-1:0]       ld_tag;
  logic [PW-1:0]       ld_pri;
  spq_pkg::spq_status_e ld_stat;
  logic                ld_last;

  logic                out_free;
  logic                in_ready;
  logic                in_acc;
  logic                last_step;
  spq_pkg::spq_kind_e  in_kind;
  spq_pkg::spq_ctrl_t  ctrl;

  logic [TAG_BITS-1:0] in_tag_st;
  logic [TW-1:0]       in_tag_echo;
  logic [TW-1:0]       head_tag_out;

  logic [TAG_BITS-1:0] cell_tag  [DEPTH];
  logic [PW-1:0]       cell_pri  [DEPTH];
  logic                cell_keep [DEPTH];

  // Tag width conversion between the port and the stored form.
  for (genvar b = 0; b < TAG_BITS; b++) begin : g_tag_st
    if (b < TW) begin : g_bit
      assign in_tag_st[b] = in_i.tag[b];
    end else begin : g_zero
      assign in_tag_st[b] = 1'b0;
    end
  end

  for (genvar b = 0; b < TW; b++) begin : g_tag_out
    if (b < TAG_BITS) begin : g_bit
      assign in_tag_echo[b]  = in_i.tag[b];
      assign head_tag_out[b] = cell_tag[0][b];
    end else begin : g_zero
      assign in_tag_echo[b]  = 1'b0;
      assign head_tag_out[b] = 1'b0;
    end
  end

  // Row of cells; the head is slot zero.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [TAG_BITS-1:0] left_tag;
    logic [PW-1:0]       left_pri;
    logic                left_keep;
    logic [TAG_BITS-1:0] right_tag;
    logic [PW-1:0]       right_pri;

    if (i == 0) begin : g_first
      assign left_tag  = '0;
      assign left_pri  = '0;
      assign left_keep = 1'b1;
    end else begin : g_mid
      assign left_tag  = cell_tag[i-1];
      assign left_pri  = cell_pri[i-1];
      assign left_keep = cell_keep[i-1];
    end

    if (i == DEPTH - 1) begin : g_end
      assign right_tag = '0;
      assign right_pri = '0;
    end else begin : g_inner
      assign right_tag = cell_tag[i+1];
      assign right_pri = cell_pri[i+1];
    end

    spq_cell #(
      .DEPTH    (DEPTH),
      .TAG_BITS (TAG_BITS),
      .IDX      (i)
    ) u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .occ_i       (occ_q),
      .new_tag_i   (in_tag_st),
      .left_tag_i  (left_tag),
      .left_pri_i  (left_pri),
      .left_keep_i (left_keep),
      .right_tag_i (right_tag),
      .right_pri_i (right_pri),
      .head_tag_i  (cell_tag[0]),
      .head_pri_i  (cell_pri[0]),
      .tag_o       (cell_tag[i]),
      .pri_o       (cell_pri[i]),
      .keep_o      (cell_keep[i])
    );
  end

  // Handshake helpers.
  assign out_free  = !out_valid_q || out_o.ready;
  assign in_ready  = (state_q == spq_pkg::ST_IDLE) && out_free;
  assign in_acc    = in_i.valid && in_ready;
  assign in_kind   = spq_pkg::spq_kind_e'(in_i.kind);
  assign last_step = OW'(cnt_q) == (occ_q - 1'b1);

  // Next state of the sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      spq_pkg::ST_IDLE: begin
        if (in_acc && (occ_q != '0)) begin
          if (in_kind == spq_pkg::KIND_MATCH) begin
            state_d = spq_pkg::ST_MATCH;
          end else if (in_kind == spq_pkg::KIND_LIST) begin
            state_d = spq_pkg::ST_LIST;
          end
        end
      end
      spq_pkg::ST_LIST: begin
        if (out_free && last_step) begin
          state_d = spq_pkg::ST_IDLE;
        end
      end
      spq_pkg::ST_MATCH: begin
        if (out_free && last_step) begin
          state_d = spq_pkg::ST_MATCH_END;
        end
      end
      spq_pkg::ST_MATCH_END: begin
        if (out_free) begin
          state_d = spq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = spq_pkg::ST_IDLE;
      end
    endcase
  end

  // Row commands, bookkeeping and result selection.
  always_comb begin
    ctrl.op     = spq_pkg::OP_HOLD;
    ctrl.pri    = in_i.priority_req;
    occ_d       = occ_q;
    cnt_d       = cnt_q;
    pend_v_d    = pend_v_q;
    pend_tag_d  = pend_tag_q;
    pend_pri_d  = pend_pri_q;
    match_pri_d = match_pri_q;
    ld          = 1'b0;
    ld_tag      = '0;
    ld_pri      = '0;
    ld_stat     = spq_pkg::STAT_OK;
    ld_last     = 1'b1;
    case (state_q)
      spq_pkg::ST_IDLE: begin
        if (in_acc) begin
          case (in_kind)
            spq_pkg::KIND_INSERT: begin
              ld = 1'b1;
              if (occ_q == OW'(DEPTH)) begin
                ld_stat = spq_pkg::STAT_FULL;
              end else begin
                ctrl.op = spq_pkg::OP_INSERT;
                occ_d   = occ_q + 1'b1;
                ld_tag  = in_tag_echo;
                ld_pri  = in_i.priority_req;
              end
            end
            spq_pkg::KIND_POP: begin
              ld = 1'b1;
              if (occ_q == '0) begin
                ld_stat = spq_pkg::STAT_EMPTY;
              end else begin
                ctrl.op = spq_pkg::OP_POP;
                occ_d   = occ_q - 1'b1;
                ld_tag  = head_tag_out;
                ld_pri  = cell_pri[0];
              end
            end
            spq_pkg::KIND_MATCH: begin
              if (occ_q == '0) begin
                ld      = 1'b1;
                ld_stat = spq_pkg::STAT_NOMATCH;
              end else begin
                match_pri_d = in_i.priority_req;
                cnt_d       = '0;
                pend_v_d    = 1'b0;
              end
            end
            spq_pkg::KIND_LIST: begin
              if (occ_q == '0) begin
                ld      = 1'b1;
                ld_stat = spq_pkg::STAT_EMPTY;
              end else begin
                cnt_d = '0;
              end
            end
            default: begin
              ld = 1'b0;
            end
          endcase
        end
      end
      spq_pkg::ST_LIST: begin
        if (out_free) begin
          ctrl.op = spq_pkg::OP_ROTATE;
          cnt_d   = cnt_q + 1'b1;
          ld      = 1'b1;
          ld_tag  = head_tag_out;
          ld_pri  = cell_pri[0];
          ld_last = last_step;
        end
      end
      spq_pkg::ST_MATCH: begin
        if (out_free) begin
          ctrl.op = spq_pkg::OP_ROTATE;
          cnt_d   = cnt_q + 1'b1;
          // A new match releases the one held before it.
          if (cell_pri[0] == match_pri_q) begin
            ld         = pend_v_q;
            ld_tag     = pend_tag_q;
            ld_pri     = pend_pri_q;
            ld_last    = 1'b0;
            pend_v_d   = 1'b1;
            pend_tag_d = head_tag_out;
            pend_pri_d = cell_pri[0];
          end
        end
      end
      spq_pkg::ST_MATCH_END: begin
        if (out_free) begin
          ld = 1'b1;
          if (pend_v_q) begin
            ld_tag = pend_tag_q;
            ld_pri = pend_pri_q;
          end else begin
            ld_stat = spq_pkg::STAT_NOMATCH;
          end
        end
      end
      default: begin
        ld = 1'b0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= spq_pkg::ST_IDLE;
      occ_q       <= '0;
      cnt_q       <= '0;
      pend_v_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      occ_q    <= occ_d;
      cnt_q    <= cnt_d;
      pend_v_q <= pend_v_d;
      if (ld) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    pend_tag_q  <= pend_tag_d;
    pend_pri_q  <= pend_pri_d;
    match_pri_q <= match_pri_d;
    if (ld) begin
      out_tag_q  <= ld_tag;
      out_pri_q  <= ld_pri;
      out_stat_q <= ld_stat;
      out_last_q <= ld_last;
    end
  end

  assign in_i.ready         = in_ready;
  assign out_o.valid        = out_valid_q;
  assign out_o.out_tag      = out_tag_q;
  assign out_o.out_priority = out_pri_q;
  assign out_o.status       = out_stat_q;
  assign out_o.last         = out_last_q;

  // The fill count never exceeds the number of slots.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= OW'(DEPTH))
    else $error("occupancy above depth");

  // An insert with room grows the queue by exactly one entry.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (in_kind == spq_pkg::KIND_INSERT) && (occ_q != OW'(DEPTH)))
      |=> (occ_q == $past(occ_q) + 1'b1))
    else $error("insert did not grow the queue");

  // A listing never changes the number of entries.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != spq_pkg::ST_IDLE) |-> $stable(occ_q))
    else $error("occupancy changed during a listing");

  // A result that is not the final one only waits while its listing runs.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_last_q) |-> (state_q != spq_pkg::ST_IDLE))
    else $error("listing ended without a final result");

endmodule
